/* hdl/olist_pkg.sv */
package olist_pkg;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 5;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT_AT   = 3'd0,
      CMD_APPEND      = 3'd1,
      CMD_DELETE_AT   = 3'd2,
      CMD_DELETE_LAST = 3'd3,
      CMD_SEARCH      = 3'd4,
      CMD_UPDATE_AT   = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_BADPOS = 3'd2,
      ST_FULL   = 3'd3,
      ST_NOKEY  = 3'd4
   } status_type;

   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

/* hdl/olist_req_if.sv */
interface olist_req_if import olist_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   value_type            value;
   logic [POS_W-1:0]     position;

   modport source (output valid, output command, output value, output position,
                   input ready);
   modport sink   (input valid, input command, input value, input position,
                   output ready);

endinterface

/* hdl/olist_rsp_if.sv */
interface olist_rsp_if import olist_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [POS_W-1:0]     found_position;
   logic [COUNT_W-1:0]   entry_count;

   modport source (output valid, output status, output found_position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found_position,
                   input entry_count, output ready);

endinterface

/* hdl/ordered_list_engine.sv */
// a command is held in the command register and its result in the result register
// throughput: one command per cycle while results are taken; the entry shift, the match
//    compare and the count update all sit between the command and result registers
// reset: synchronous, clears the entry count and both valid flags; entry data is not cleared
module ordered_list_engine import olist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   olist_req_if.sink   req_bus,
   olist_rsp_if.source rsp_bus
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   // command register
   logic               cmd_valid_ff;
   logic [CMD_W-1:0]   cmd_ff;
   value_type          value_ff;
   logic [POS_W-1:0]   pos_ff;

   // list state
   value_type          entry_ff [CAPACITY];
   value_type          entry_in [CAPACITY];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   // result register
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  status_ff;
   logic [STAT_W-1:0]  status_in;
   logic [POS_W-1:0]   found_ff;
   logic [POS_W-1:0]   found_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               advance;

   // a command moves into the result register when that register is free or draining
   assign advance       = cmd_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !cmd_valid_ff || advance;

   // command register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         cmd_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         cmd_ff   <= req_bus.command;
         value_ff <= req_bus.value;
         pos_ff   <= req_bus.position;
      end
   end

   // command execution
   always_comb begin
      logic [CMPW-1:0] pos_x;
      logic [CMPW-1:0] cnt_x;
      logic [CMPW-1:0] idx_x;
      logic            pos_zero;
      logic            full;
      logic            hit;
      pos_x    = CMPW'(pos_ff);
      cnt_x    = CMPW'(count_ff);
      idx_x    = pos_x - CMPW'(1);
      pos_zero = (pos_ff == '0);
      full     = (count_ff == CW'(CAPACITY));
      hit      = 1'b0;
      entry_in  = entry_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      found_in  = '0;
      case (cmd_type'(cmd_ff))
         CMD_INSERT_AT: begin
            if (pos_zero || pos_x > cnt_x + CMPW'(1)) begin
               status_in = ST_BADPOS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               for (int k = 0; k < CAPACITY; k++) begin
                  if (CMPW'(k) == idx_x) begin
                     entry_in[k] = value_ff;
                  end
               end
               // entries behind the insert point move back by one
               for (int k = 1; k < CAPACITY; k++) begin
                  if (CMPW'(k) > idx_x) begin
                     entry_in[k] = entry_ff[k-1];
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         CMD_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               for (int k = 0; k < CAPACITY; k++) begin
                  if (CW'(k) == count_ff) begin
                     entry_in[k] = value_ff;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         CMD_DELETE_AT: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (pos_zero || pos_x > cnt_x) begin
               status_in = ST_BADPOS;
            end else begin
               for (int k = 0; k < CAPACITY - 1; k++) begin
                  if (CMPW'(k) >= idx_x) begin
                     entry_in[k] = entry_ff[k+1];
                  end
               end
               count_in = count_ff - CW'(1);
            end
         end
         CMD_DELETE_LAST: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         CMD_SEARCH: begin
            // priority pick of the lowest matching held entry
            for (int k = CAPACITY - 1; k >= 0; k--) begin
               if (CW'(k) < count_ff && entry_ff[k] == value_ff) begin
                  hit      = 1'b1;
                  found_in = POS_W'(k + 1);
               end
            end
            status_in = hit ? ST_OK : ST_NOKEY;
         end
         CMD_UPDATE_AT: begin
            if (pos_zero || pos_x > cnt_x) begin
               status_in = ST_BADPOS;
            end else begin
               for (int k = 0; k < CAPACITY; k++) begin
                  if (CMPW'(k) == idx_x) begin
                     entry_in[k] = value_ff;
                  end
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // list state update
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.found_position = found_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;

   // the list never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // a pending result reports the count the list currently holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == COUNT_W'(count_ff)))
      else $error("result count differs from held count");

   // the list changes only when a command executes
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("count changed without a command");

   // a found position comes only with a successful search
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff != '0) |-> (status_ff == ST_OK))
      else $error("found position with failing status");

   // the count moves by at most one per command
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1)
                   || count_ff == $past(count_ff) - CW'(1)))
      else $error("count stepped by more than one");

endmodule
